@@ hdl/rhc_pkg.sv @@
package rhc_pkg;

   localparam int SAT_SCALE   = 240;
   localparam int LIGHT_SCALE = 240;
   localparam int DIV_STEPS   = 8;

   localparam logic [1:0] SECT_RED   = 2'd0;
   localparam logic [1:0] SECT_GREEN = 2'd1;
   localparam logic [1:0] SECT_BLUE  = 2'd2;

   // one restoring divider lane: remainder, shifted divisor, quotient so far
   typedef struct packed {
      logic [16:0] rem;
      logic [15:0] dsh;
      logic [7:0]  quo;
   } div_lane_type;

   typedef struct packed {
      logic         vld;
      logic [1:0]   sector;
      logic         neg;
      logic         grey;
      div_lane_type sat;
      div_lane_type hue;
      div_lane_type lit;
   } cell_type;

   function automatic div_lane_type div_step(input div_lane_type l);
      div_lane_type o;
      o = l;
      if (l.rem >= {1'b0, l.dsh}) begin
         o.rem = l.rem - {1'b0, l.dsh};
         o.quo = {l.quo[6:0], 1'b1};
      end else begin
         o.quo = {l.quo[6:0], 1'b0};
      end
      o.dsh = {1'b0, l.dsh[15:1]};
      return o;
   endfunction

endpackage

@@ hdl/rgb_to_hsl_convert.sv @@
// rgb to hsl pixel converter
// pipeline: 1 front stage loaded at the start edge, 8 divider cells, 1 output stage
// throughput: one item every cycle, busy is always low, result cannot be stalled
// reset: synchronous, active high, clears every valid bit in the chain
module rgb_to_hsl_convert (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       rsp_valid,
   output logic [8:0] rsp_hue,
   output logic [7:0] rsp_saturation,
   output logic [7:0] rsp_lightness
);
   import rhc_pkg::*;

   // chain of cells: index 0 is the front stage output
   cell_type chain [DIV_STEPS+1];

   // the pipeline never stalls, so an item can enter every cycle
   assign busy = 1'b0;

   // max/min, sector choice and the three numerator/divisor pairs
   rhc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (start),
      .red     (req_red),
      .green   (req_green),
      .blue    (req_blue),
      .cell_ff (chain[0])
   );

   // each cell resolves one quotient bit of saturation, hue and lightness
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      rhc_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cell_i  (chain[i]),
         .cell_ff (chain[i+1])
      );
   end

   // hue assembly from sector base, grey override, output register
   rhc_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cell_i (chain[DIV_STEPS]),
      .vld_ff (rsp_valid),
      .hue_ff (rsp_hue),
      .sat_ff (rsp_saturation),
      .lit_ff (rsp_lightness)
   );

   // hue stays inside one turn
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hue < 9'd360)
      else $error("hue out of range");

   // saturation and lightness never exceed their scales
   a_scale_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_saturation <= 8'(SAT_SCALE) && rsp_lightness <= 8'(LIGHT_SCALE)))
      else $error("scaled value out of range");

   // a grey item reaching the output stage yields zero hue and saturation
   a_grey_zero: assert property (@(posedge clock) disable iff (reset)
      (chain[DIV_STEPS].vld && chain[DIV_STEPS].grey) |=>
         (rsp_hue == 9'd0 && rsp_saturation == 8'd0))
      else $error("grey item with nonzero hue or saturation");

endmodule

@@ hdl/rhc_front.sv @@
module rhc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_vld,
   input  logic [7:0]        red,
   input  logic [7:0]        green,
   input  logic [7:0]        blue,
   output rhc_pkg::cell_type cell_ff
);
   import rhc_pkg::*;

   logic [7:0] mx, mn, diff, pos, neg, d;
   logic [8:0] sum, den_s;
   logic [1:0] sect;
   cell_type   cell_in;

   always_comb begin
      mx = red;
      mn = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      diff = mx - mn;
      sum = {1'b0, mx} + {1'b0, mn};
      den_s = (sum <= 9'd255) ? sum : 9'd510 - sum;
      // red max wins over green, green over blue
      if (red == mx) begin
         sect = SECT_RED;
         pos = green;
         neg = blue;
      end else if (green == mx) begin
         sect = SECT_GREEN;
         pos = blue;
         neg = red;
      end else begin
         sect = SECT_BLUE;
         pos = red;
         neg = green;
      end
      d = (pos >= neg) ? pos - neg : neg - pos;

      cell_in.vld = in_vld;
      cell_in.sector = sect;
      cell_in.neg = (pos < neg);
      cell_in.grey = (diff == 8'd0);
      cell_in.sat.rem = 17'(SAT_SCALE * int'(diff));
      cell_in.sat.dsh = {den_s, 7'd0};
      cell_in.sat.quo = 8'd0;
      cell_in.hue.rem = 17'(60 * int'(d));
      cell_in.hue.dsh = {1'b0, diff, 7'd0};
      cell_in.hue.quo = 8'd0;
      cell_in.lit.rem = 17'(LIGHT_SCALE * int'(sum));
      cell_in.lit.dsh = {9'd510, 7'd0};
      cell_in.lit.quo = 8'd0;
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end
   end

endmodule

@@ hdl/rhc_div_cell.sv @@
module rhc_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  rhc_pkg::cell_type cell_i,
   output rhc_pkg::cell_type cell_ff
);
   import rhc_pkg::*;

   cell_type cell_in;

   always_comb begin
      cell_in = cell_i;
      cell_in.sat = div_step(cell_i.sat);
      cell_in.hue = div_step(cell_i.hue);
      cell_in.lit = div_step(cell_i.lit);
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end
   end

endmodule

@@ hdl/rhc_back.sv @@
module rhc_back (
   input  logic              clock,
   input  logic              reset,
   input  rhc_pkg::cell_type cell_i,
   output logic              vld_ff,
   output logic [8:0]        hue_ff,
   output logic [7:0]        sat_ff,
   output logic [7:0]        lit_ff
);
   import rhc_pkg::*;

   logic [9:0] base, h, hue_in;
   logic [7:0] sat_in;

   always_comb begin
      unique case (cell_i.sector)
         SECT_RED:   base = 10'd360;
         SECT_GREEN: base = 10'd120;
         SECT_BLUE:  base = 10'd240;
         default:    base = 10'd0;
      endcase
      // negative offset floors, so round the magnitude up
      if (cell_i.neg) begin
         h = base - {2'b0, cell_i.hue.quo} - {9'd0, (cell_i.hue.rem != 17'd0)};
      end else begin
         h = base + {2'b0, cell_i.hue.quo};
      end
      hue_in = (h >= 10'd360) ? h - 10'd360 : h;
      sat_in = cell_i.sat.quo;
      if (cell_i.grey) begin
         hue_in = 10'd0;
         sat_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      hue_ff <= hue_in[8:0];
      sat_ff <= sat_in;
      lit_ff <= cell_i.lit.quo;
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= cell_i.vld;
      end
   end

endmodule

@@ tb/sv/rgb_to_hsl_convert_test.sv @@
`timescale 1ns / 100ps

module rgb_to_hsl_convert_test;
   import rhc_pkg::*;

   // one pixel as offered on the request ports
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // one converted pixel as seen on the response ports
   typedef struct packed {
      logic [8:0] hue;
      logic [7:0] saturation;
      logic [7:0] lightness;
   } hsl_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [7:0] req_red = '0;
   logic [7:0] req_green = '0;
   logic [7:0] req_blue = '0;
   logic       rsp_valid;
   logic [8:0] rsp_hue;
   logic [7:0] rsp_saturation;
   logic [7:0] rsp_lightness;

   pixel_type pending_pixels[$];
   hsl_type   expected_hsl[$];
   int        error_count = 0;
   int        pixels_sent = 0;
   int        pixels_checked = 0;
   int        grey_seen = 0;
   int        cycle_count = 0;
   bit        stimulus_done = 1'b0;

   rgb_to_hsl_convert DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .rsp_valid(rsp_valid),
      .rsp_hue(rsp_hue),
      .rsp_saturation(rsp_saturation),
      .rsp_lightness(rsp_lightness)
   );

   always #1 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // base + floor(60*(pos-neg)/span), folded into 0..359
   function automatic int hue_in_sector(int base, int pos, int neg, int span);
      int h;
      if (pos >= neg) begin
         h = base + (60 * (pos - neg)) / span;
      end else begin
         h = base - (60 * (neg - pos) + span - 1) / span;
      end
      while (h >= 360) h -= 360;
      return h;
   endfunction

   // integer hsl conversion of one pixel
   function automatic hsl_type convert_pixel(pixel_type p);
      hsl_type o;
      int r, g, b, hi, lo, span, total;
      r = p.red;
      g = p.green;
      b = p.blue;
      hi = r;
      lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      span = hi - lo;
      total = hi + lo;
      o.lightness = 8'((LIGHT_SCALE * total) / 510);
      if (span == 0) begin
         // grey pixel: no hue, no saturation
         o.hue = '0;
         o.saturation = '0;
      end else begin
         if (total <= 255) begin
            o.saturation = 8'((SAT_SCALE * span) / total);
         end else begin
            o.saturation = 8'((SAT_SCALE * span) / (510 - total));
         end
         // red max wins ties, then green, then blue
         if (r == hi) begin
            o.hue = 9'(hue_in_sector(360, g, b, span));
         end else if (g == hi) begin
            o.hue = 9'(hue_in_sector(120, b, r, span));
         end else begin
            o.hue = 9'(hue_in_sector(240, r, g, span));
         end
      end
      return o;
   endfunction

   function automatic pixel_type make_pixel(int r, int g, int b);
      pixel_type p;
      p.red = 8'(r);
      p.green = 8'(g);
      p.blue = 8'(b);
      return p;
   endfunction

   // driver: idles at random with a 29 percent chance, except for a burst window
   always @(posedge clock) begin
      bit idle;
      pixel_type p;
      if (reset) begin
         start <= 1'b0;
      end else begin
         // item accepted at this edge when start was high and busy low
         if (start && !busy) begin
            expected_hsl.push_back(convert_pixel({req_red, req_green, req_blue}));
            pixels_sent <= pixels_sent + 1;
            void'(pending_pixels.pop_front());
         end
         idle = ($urandom_range(99) < 29) && !(pixels_sent > 300 && pixels_sent < 450);
         if (pending_pixels.size() > 0 && !idle) begin
            p = pending_pixels[0];
            start <= 1'b1;
            req_red <= p.red;
            req_green <= p.green;
            req_blue <= p.blue;
         end else begin
            start <= 1'b0;
            req_red <= 8'($urandom);
            req_green <= 8'($urandom);
            req_blue <= 8'($urandom);
         end
      end
   end

   // monitor: every strobed result must match the oldest prediction
   always @(posedge clock) begin
      hsl_type want;
      if (!reset && rsp_valid) begin
         if (expected_hsl.size() == 0) begin
            $error("unexpected result hue=%0d sat=%0d light=%0d",
                   rsp_hue, rsp_saturation, rsp_lightness);
            error_count <= error_count + 1;
         end else begin
            want = expected_hsl.pop_front();
            if (want.saturation == 0) grey_seen <= grey_seen + 1;
            pixels_checked <= pixels_checked + 1;
            if (rsp_hue !== want.hue) begin
               $error("hue expected %0d actual %0d", want.hue, rsp_hue);
               error_count <= error_count + 1;
            end
            if (rsp_saturation !== want.saturation) begin
               $error("saturation expected %0d actual %0d",
                      want.saturation, rsp_saturation);
               error_count <= error_count + 1;
            end
            if (rsp_lightness !== want.lightness) begin
               $error("lightness expected %0d actual %0d",
                      want.lightness, rsp_lightness);
               error_count <= error_count + 1;
            end
         end
      end
   end

   // stimulus
   initial begin
      int mode, a, c;
      // directed: extremes, grey pixels, each sector, pure red wrap, ties
      pending_pixels.push_back(make_pixel(0, 0, 0));
      pending_pixels.push_back(make_pixel(255, 255, 255));
      pending_pixels.push_back(make_pixel(128, 128, 128));
      pending_pixels.push_back(make_pixel(255, 0, 0));
      pending_pixels.push_back(make_pixel(0, 255, 0));
      pending_pixels.push_back(make_pixel(0, 0, 255));
      pending_pixels.push_back(make_pixel(255, 255, 0));
      pending_pixels.push_back(make_pixel(0, 255, 255));
      pending_pixels.push_back(make_pixel(255, 0, 255));
      pending_pixels.push_back(make_pixel(200, 50, 50));
      pending_pixels.push_back(make_pixel(255, 0, 1));
      pending_pixels.push_back(make_pixel(255, 1, 0));
      pending_pixels.push_back(make_pixel(1, 0, 0));
      pending_pixels.push_back(make_pixel(255, 254, 254));
      pending_pixels.push_back(make_pixel(1, 0, 1));
      pending_pixels.push_back(make_pixel(0, 1, 0));
      pending_pixels.push_back(make_pixel(127, 128, 0));
      pending_pixels.push_back(make_pixel(128, 127, 255));
      pending_pixels.push_back(make_pixel(10, 200, 255));
      pending_pixels.push_back(make_pixel(170, 85, 170));
      for (int i = 0; i < 850; i++) begin
         mode = $urandom_range(9);
         case (mode)
            0: begin
               // grey
               a = $urandom_range(255);
               pending_pixels.push_back(make_pixel(a, a, a));
            end
            1: begin
               // red max with green equal to blue, and near it
               a = $urandom_range(255);
               c = $urandom_range(a);
               pending_pixels.push_back(make_pixel(a, c, c + $urandom_range(1) * (c < a)));
            end
            2: begin
               // small span near a single level
               a = $urandom_range(250);
               pending_pixels.push_back(make_pixel(a + $urandom_range(3),
                  a + $urandom_range(3), a + $urandom_range(3)));
            end
            3: begin
               // red and green at 0 or 255, blue random
               pending_pixels.push_back(make_pixel(255 * $urandom_range(1),
                  255 * $urandom_range(1), $urandom_range(255)));
            end
            default: begin
               pending_pixels.push_back(make_pixel($urandom_range(255),
                  $urandom_range(255), $urandom_range(255)));
            end
         endcase
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (pending_pixels.size() == 0);
      @(posedge clock);
      wait (expected_hsl.size() == 0);
      // pipeline is ten deep; let stray strobes show up
      repeat (20) @(posedge clock);
      $display("converted %0d pixels (%0d grey or unsaturated) in %0d cycles",
               pixels_checked, grey_seen, cycle_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #200000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
